### rtl/m6502alu_pkg.sv
package m6502alu_pkg;

    typedef enum logic [4:0] {
        ACT_ADC = 5'd0,
        ACT_SBC = 5'd1,
        ACT_AND = 5'd2,
        ACT_ORA = 5'd3,
        ACT_EOR = 5'd4,
        ACT_BIT = 5'd5,
        ACT_CMP = 5'd6,
        ACT_CPX = 5'd7,
        ACT_CPY = 5'd8,
        ACT_LDA = 5'd9,
        ACT_LDX = 5'd10,
        ACT_LDY = 5'd11,
        ACT_ASL = 5'd12,
        ACT_LSR = 5'd13,
        ACT_ROL = 5'd14,
        ACT_ROR = 5'd15,
        ACT_INC = 5'd16,
        ACT_DEC = 5'd17,
        ACT_INX = 5'd18,
        ACT_INY = 5'd19,
        ACT_DEX = 5'd20,
        ACT_DEY = 5'd21,
        ACT_TAX = 5'd22,
        ACT_TAY = 5'd23,
        ACT_TSX = 5'd24,
        ACT_TXA = 5'd25,
        ACT_TXS = 5'd26,
        ACT_TYA = 5'd27
    } action_t;

    // Architectural register file of the core.
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] xreg;
        logic [7:0] yreg;
        logic [7:0] sp;
        logic [7:0] status;
    } arch_state_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

endpackage

### rtl/m6502alu_exec.sv
module m6502alu_exec (
    input  logic [4:0]                 action,
    input  logic [7:0]                 operand,
    input  m6502alu_pkg::arch_state_t  state,
    output m6502alu_pkg::arch_state_t  state_next,
    output logic [7:0]                 result
);

    logic [7:0] add_b;
    logic [8:0] sum9;
    logic       add_v;
    logic [7:0] cmp_reg;
    logic [8:0] diff9;
    logic       carry_in;

    assign carry_in = state.status[m6502alu_pkg::FLAG_C];

    // SBC is ADC of the inverted operand.
    assign add_b = (action == m6502alu_pkg::ACT_SBC) ? ~operand : operand;
    assign sum9  = {1'b0, state.acc} + {1'b0, add_b} + {8'd0, carry_in};
    assign add_v = ~(state.acc[7] ^ add_b[7]) & (state.acc[7] ^ sum9[7]);

    always_comb begin
        unique case (action)
            m6502alu_pkg::ACT_CPX: cmp_reg = state.xreg;
            m6502alu_pkg::ACT_CPY: cmp_reg = state.yreg;
            default:               cmp_reg = state.acc;
        endcase
    end

    // Bit 8 is the borrow, so carry is its inverse.
    assign diff9 = {1'b0, cmp_reg} - {1'b0, operand};

    always_comb begin
        logic [7:0] nz_val;
        logic       nz_en;
        state_next = state;
        result     = 8'd0;
        nz_val     = 8'd0;
        nz_en      = 1'b0;
        unique case (action)
            m6502alu_pkg::ACT_ADC,
            m6502alu_pkg::ACT_SBC: begin
                state_next.acc = sum9[7:0];
                state_next.status[m6502alu_pkg::FLAG_C] = sum9[8];
                state_next.status[m6502alu_pkg::FLAG_V] = add_v;
                nz_val = sum9[7:0];
                nz_en  = 1'b1;
                result = sum9[7:0];
            end
            m6502alu_pkg::ACT_AND: begin
                nz_val = state.acc & operand;
                nz_en  = 1'b1;
                state_next.acc = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_ORA: begin
                nz_val = state.acc | operand;
                nz_en  = 1'b1;
                state_next.acc = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_EOR: begin
                nz_val = state.acc ^ operand;
                nz_en  = 1'b1;
                state_next.acc = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_BIT: begin
                state_next.status[m6502alu_pkg::FLAG_Z] = ((state.acc & operand) == 8'd0);
                state_next.status[m6502alu_pkg::FLAG_V] = operand[6];
                state_next.status[m6502alu_pkg::FLAG_N] = operand[7];
            end
            m6502alu_pkg::ACT_CMP,
            m6502alu_pkg::ACT_CPX,
            m6502alu_pkg::ACT_CPY: begin
                state_next.status[m6502alu_pkg::FLAG_C] = ~diff9[8];
                nz_val = diff9[7:0];
                nz_en  = 1'b1;
            end
            m6502alu_pkg::ACT_LDA: begin
                nz_val = operand;
                nz_en  = 1'b1;
                state_next.acc = operand;
                result = operand;
            end
            m6502alu_pkg::ACT_LDX: begin
                nz_val = operand;
                nz_en  = 1'b1;
                state_next.xreg = operand;
                result = operand;
            end
            m6502alu_pkg::ACT_LDY: begin
                nz_val = operand;
                nz_en  = 1'b1;
                state_next.yreg = operand;
                result = operand;
            end
            m6502alu_pkg::ACT_ASL: begin
                state_next.status[m6502alu_pkg::FLAG_C] = operand[7];
                nz_val = {operand[6:0], 1'b0};
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_LSR: begin
                state_next.status[m6502alu_pkg::FLAG_C] = operand[0];
                nz_val = {1'b0, operand[7:1]};
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_ROL: begin
                state_next.status[m6502alu_pkg::FLAG_C] = operand[7];
                nz_val = {operand[6:0], carry_in};
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_ROR: begin
                state_next.status[m6502alu_pkg::FLAG_C] = operand[0];
                nz_val = {carry_in, operand[7:1]};
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_INC: begin
                nz_val = operand + 8'd1;
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_DEC: begin
                nz_val = operand - 8'd1;
                nz_en  = 1'b1;
                result = nz_val;
            end
            m6502alu_pkg::ACT_INX: begin
                nz_val = state.xreg + 8'd1;
                nz_en  = 1'b1;
                state_next.xreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_INY: begin
                nz_val = state.yreg + 8'd1;
                nz_en  = 1'b1;
                state_next.yreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_DEX: begin
                nz_val = state.xreg - 8'd1;
                nz_en  = 1'b1;
                state_next.xreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_DEY: begin
                nz_val = state.yreg - 8'd1;
                nz_en  = 1'b1;
                state_next.yreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_TAX: begin
                nz_val = state.acc;
                nz_en  = 1'b1;
                state_next.xreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_TAY: begin
                nz_val = state.acc;
                nz_en  = 1'b1;
                state_next.yreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_TSX: begin
                nz_val = state.sp;
                nz_en  = 1'b1;
                state_next.xreg = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_TXA: begin
                nz_val = state.xreg;
                nz_en  = 1'b1;
                state_next.acc = nz_val;
                result = nz_val;
            end
            m6502alu_pkg::ACT_TXS: begin
                // The stack pointer transfer leaves every flag alone.
                state_next.sp = state.xreg;
                result = state.xreg;
            end
            m6502alu_pkg::ACT_TYA: begin
                nz_val = state.yreg;
                nz_en  = 1'b1;
                state_next.acc = nz_val;
                result = nz_val;
            end
            default: begin
            end
        endcase
        if (nz_en) begin
            state_next.status[m6502alu_pkg::FLAG_Z] = (nz_val == 8'd0);
            state_next.status[m6502alu_pkg::FLAG_N] = nz_val[7];
        end
    end

endmodule

### rtl/mos6502_alu_register_file.sv
// An accepted word goes from the input register to the result register.
// Throughput: one word per cycle unless the output stalls; the 8-bit adder and flag
// logic sit between the two registers, and A, X, Y, S and P update there.
// Reset (aresetn low, synchronous) clears A, X, Y, S and P and empties both stages.
module mos6502_alu_register_file (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [4:0] s_action,
    input  logic [7:0] s_operand,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_value,
    output logic [7:0] m_acc_out,
    output logic [7:0] m_xreg_out,
    output logic [7:0] m_yreg_out,
    output logic [7:0] m_stack_ptr_out,
    output logic [7:0] m_status_out
);

    logic                      in_valid_reg;
    logic [4:0]                action_reg;
    logic [7:0]                operand_reg;
    logic                      out_valid_reg;
    logic [7:0]                result_reg;
    m6502alu_pkg::arch_state_t state_reg;
    m6502alu_pkg::arch_state_t state_next;
    m6502alu_pkg::arch_state_t out_state_reg;
    logic [7:0]                result_next;
    logic                      advance;
    logic                      take_in;

    // A word executes when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take_in = s_valid && s_ready;

    m6502alu_exec u_exec (
        .action     (action_reg),
        .operand    (operand_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (take_in) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            action_reg  <= s_action;
            operand_reg <= s_operand;
        end
        if (advance) begin
            result_reg    <= result_next;
            out_state_reg <= state_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_value  = result_reg;
    assign m_acc_out       = out_state_reg.acc;
    assign m_xreg_out      = out_state_reg.xreg;
    assign m_yreg_out      = out_state_reg.yreg;
    assign m_stack_ptr_out = out_state_reg.sp;
    assign m_status_out    = out_state_reg.status;

endmodule
